>>> sv/kcd_pkg.sv
`timescale 1ns / 1ps

package kcd_pkg;

    localparam int KEYS_DEFAULT       = 8;
    localparam int PRESS_BITS_DEFAULT = 16;
    localparam int MAX_LANES          = 8;

    localparam int LEVEL_W     = 8;
    localparam int KEY_NUM_W   = 3;
    localparam int KIND_W      = 2;
    localparam int ACTIVE_W    = 4;
    localparam int LONG_W      = 16;
    localparam int RELEASE_W   = 8;
    localparam int TALLY_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [RELEASE_W-1:0] RELEASE_MAX      = 8'hFF;
    localparam logic [TALLY_W-1:0]   TALLY_MAX        = 2'd3;
    localparam logic [TALLY_W-1:0]   DOUBLE_MIN_TALLY = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CLICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_KEYS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_LEVELS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_TICKS   = 3'd3;

    localparam logic [ACTIVE_W-1:0]  ACTIVE_KEYS_RESET  = 4'd0;
    localparam logic [LONG_W-1:0]    LONG_TICKS_RESET   = 16'd100;
    localparam logic [RELEASE_W-1:0] DOUBLE_TICKS_RESET = 8'd30;

    typedef struct packed {
        logic [LONG_W-1:0]    long_ticks;
        logic [RELEASE_W-1:0] double_ticks;
    } lane_cfg_t;

    typedef struct packed {
        logic step;
        logic level;
        logic load;
        logic load_level;
    } lane_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } lane_event_t;

endpackage

>>> sv/kcd_if.sv
`timescale 1ns / 1ps

interface kcd_tick_if;
    logic                       valid;
    logic                       ready;
    logic [kcd_pkg::LEVEL_W-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kcd_event_if;
    logic                         valid;
    logic                         ready;
    logic [kcd_pkg::KEY_NUM_W-1:0] key_number;
    logic [kcd_pkg::KIND_W-1:0]    event_kind;
    logic                         last_event;

    modport source (output valid, output key_number, output event_kind, output last_event,
                    input ready);
    modport sink   (input valid, input key_number, input event_kind, input last_event,
                    output ready);
endinterface

>>> sv/kcd_lane.sv
`timescale 1ns / 1ps

module kcd_lane #(
    parameter int PRESS_BITS = kcd_pkg::PRESS_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kcd_pkg::lane_ctrl_t  ctrl,
    input  kcd_pkg::lane_cfg_t   cfg,
    output kcd_pkg::lane_event_t evt
);
    import kcd_pkg::*;

    localparam int CMP_W = (PRESS_BITS > LONG_W) ? PRESS_BITS : LONG_W;

    logic                  prev_reg, prev_next;
    logic [PRESS_BITS-1:0] press_reg, press_next;
    logic [RELEASE_W-1:0]  release_reg, release_next;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    logic                  long_reg, long_next;

    logic                  falling, rising;
    logic [PRESS_BITS-1:0] press_base, press_inc;
    logic [RELEASE_W-1:0]  release_base;
    logic                  long_base, long_hit;

    always_comb
    begin
        falling      = prev_reg & ~ctrl.level;
        rising       = ~prev_reg & ctrl.level;
        press_base   = falling ? '0 : press_reg;
        release_base = falling ? '0 : release_reg;
        long_base    = falling ? 1'b0 : long_reg;
        press_inc    = (press_base != '1) ? press_base + 1'b1 : press_base;
        long_hit     = ~ctrl.level && !long_base &&
                       (CMP_W'(press_inc) == CMP_W'(cfg.long_ticks));

        tally_next = tally_reg;
        if (falling)
        begin
            if (release_reg != '0 && release_reg <= cfg.double_ticks)
            begin
                tally_next = (tally_reg != TALLY_MAX) ? tally_reg + 1'b1 : tally_reg;
            end
            else
            begin
                tally_next = 2'd1;
            end
        end

        prev_next    = ctrl.level;
        long_next    = long_base | long_hit;
        press_next   = press_base;
        release_next = release_base;
        evt.hit      = 1'b0;
        evt.kind     = KIND_CLICK;

        if (!ctrl.level)
        begin
            press_next = press_inc;
            if (long_hit)
            begin
                evt.hit  = 1'b1;
                evt.kind = KIND_LONG;
            end
        end
        else if (rising)
        begin
            release_next = '0;
            press_next   = '0;
            if (!long_base)
            begin
                evt.hit  = 1'b1;
                evt.kind = (tally_reg >= DOUBLE_MIN_TALLY) ? KIND_DOUBLE : KIND_CLICK;
            end
        end
        else
        begin
            release_next = (release_base != RELEASE_MAX) ? release_base + 1'b1 : release_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b1;
            press_reg   <= '0;
            release_reg <= '0;
            tally_reg   <= '0;
            long_reg    <= 1'b0;
        end
        else if (ctrl.load)
        begin
            prev_reg <= ctrl.load_level;
        end
        else if (ctrl.step)
        begin
            prev_reg    <= prev_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            tally_reg   <= tally_next;
            long_reg    <= long_next;
        end
    end

endmodule

>>> sv/kcd_merge.sv
`timescale 1ns / 1ps

module kcd_merge #(
    parameter int LANES = kcd_pkg::MAX_LANES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  kcd_pkg::lane_event_t lane_evt [LANES],
    input  logic [LANES-1:0]     scanned,
    output logic                 ready,
    kcd_event_if.source          events
);
    import kcd_pkg::*;

    logic [LANES-1:0]  pending_reg, pending_next;
    logic [KIND_W-1:0] kind_reg [LANES];
    logic [LANES-1:0]  sel_mask;
    logic              last, fire;

    always_comb
    begin
        sel_mask          = '0;
        events.key_number = '0;
        events.event_kind = KIND_CLICK;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                sel_mask          = '0;
                sel_mask[i]       = 1'b1;
                events.key_number = KEY_NUM_W'(i);
                events.event_kind = kind_reg[i];
            end
        end
        last              = (pending_reg & (pending_reg - 1'b1)) == '0;
        events.valid      = |pending_reg;
        events.last_event = last;
        fire              = events.valid & events.ready;
        ready             = ~events.valid | (fire & last);

        pending_next = fire ? (pending_reg & ~sel_mask) : pending_reg;
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pending_next[i] = lane_evt[i].hit & scanned[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                kind_reg[i] <= lane_evt[i].kind;
            end
        end
    end

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last && !load |=> events.valid)
        else $error("events ran dry before the last one of the tick");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last && !load |=> !events.valid)
        else $error("events left over after the last one of the tick");

    a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load && ((lane_evt[0].hit && scanned[0]) || (pending_next != '0)) |=> events.valid)
        else $error("a tick with events did not present them");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid |-> events.event_kind != KIND_UNUSED)
        else $error("event kind out of range");

endmodule

>>> sv/key_click_double_long_detector.sv
`timescale 1ns / 1ps

// Click, double-click and long-press detector for up to eight active-low keys.
// Each request on the tick channel carries one scan of the key levels; every
// scanned key (the lowest active_keys of them, at most KEYS and at most eight)
// is processed by its own lane in the cycle the request is accepted, and the
// events found are handed to a merging stage that sends them out one per cycle
// while the receiver is ready, in key order, with last_event set on the final
// event of the tick. All events of a tick share the single result port, and
// the next tick is accepted in the cycle its last event is taken. There is no
// clearing pass after reset. Configuration must be written only while the
// block is idle, which the block itself does not enforce; writing
// initial_levels also reloads the stored level of every key.

module key_click_double_long_detector #(
    parameter int KEYS       = kcd_pkg::KEYS_DEFAULT,
    parameter int PRESS_BITS = kcd_pkg::PRESS_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    kcd_tick_if.sink                           ticks,
    kcd_event_if.source                        events,
    input  logic                               cfg_we,
    input  logic [kcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kcd_pkg::*;

    // Only eight key levels exist in a tick, so the lane count is capped.
    localparam int LANES = (KEYS < MAX_LANES) ? KEYS : MAX_LANES;

    logic [ACTIVE_W-1:0]  active_keys_reg;
    logic [LONG_W-1:0]    long_ticks_reg;
    logic [RELEASE_W-1:0] double_ticks_reg;

    logic        accept;
    logic        merge_ready;
    logic        level_load;
    lane_cfg_t   lane_cfg;
    lane_ctrl_t  lane_ctrl [LANES];
    lane_event_t lane_evt  [LANES];
    logic [LANES-1:0] scanned;

    // Configuration registers. An unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_keys_reg  <= ACTIVE_KEYS_RESET;
            long_ticks_reg   <= LONG_TICKS_RESET;
            double_ticks_reg <= DOUBLE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_KEYS:    active_keys_reg  <= cfg_data[ACTIVE_W-1:0];
                REG_LONG_TICKS:     long_ticks_reg   <= cfg_data[LONG_W-1:0];
                REG_DOUBLE_TICKS:   double_ticks_reg <= cfg_data[RELEASE_W-1:0];
                default:            ;
            endcase
        end
    end

    // The initial levels are not kept; a write just reloads every lane.
    assign level_load = cfg_we && (cfg_index == REG_INITIAL_LEVELS);

    // A tick is taken once the previous tick's events are gone or leaving.
    assign ticks.ready = merge_ready;
    assign accept      = ticks.valid & merge_ready;

    assign lane_cfg.long_ticks   = long_ticks_reg;
    assign lane_cfg.double_ticks = double_ticks_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        // Lane g is scanned when active_keys exceeds its index.
        assign scanned[g] = active_keys_reg > ACTIVE_W'(g);

        assign lane_ctrl[g].step       = accept & scanned[g];
        assign lane_ctrl[g].level      = ticks.key_levels[g];
        assign lane_ctrl[g].load       = level_load;
        assign lane_ctrl[g].load_level = cfg_data[g];

        kcd_lane #(
            .PRESS_BITS (PRESS_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl[g]),
            .cfg   (lane_cfg),
            .evt   (lane_evt[g])
        );
    end

    // The merging stage holds one tick's events and serializes them.
    kcd_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .lane_evt (lane_evt),
        .scanned  (scanned),
        .ready    (merge_ready),
        .events   (events)
    );

endmodule
